@@ src/plc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_pkg: shared types for the priority lock arbiter
// Request codes, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_QUEUED  = 3'd1,
        ST_WAITING = 3'd2,
        ST_FULL    = 3'd3,
        ST_HANDED  = 3'd4,
        ST_FREED   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_INSERT,
        SEQ_HEAD,
        SEQ_PULL
    } seq_state_t;

endpackage

@@ src/plc_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_mem: waiting list storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module plc_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/priority_lock_arbiter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_lock_arbiter: lock with a waiting list sorted by descending id
// Grants a free lock at once, queues other acquirers in id order and hands
// the lock to the highest waiting id on release.
// ----------------------------------------------------------------------------
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  request   | start (taken if !busy)| command, requester_id
//  result    | done (one-cycle pulse)| status, owner_id, is_locked, waiting_count
//
// An acquire that grants, refuses a zero id, meets the holder or queues on an
// empty list, and a release with nobody waiting, strobe done in the cycle
// after the request and never raise busy. Any other acquire walks the list
// once, one entry a cycle through the single memory read port. A release
// with waiters pulls the list up one entry a cycle. Reset clears the lock and
// the fill count; list entries beyond the count are never used, so the memory
// needs no clearing pass. The receiver cannot stall: each result is valid
// only in its done cycle.
// ----------------------------------------------------------------------------
module priority_lock_arbiter
    import plc_pkg::*;
#(
    parameter int LIST_DEPTH = 16,
    parameter int ID_BITS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [15:0] requester_id,
    output logic        done,
    output logic [2:0]  status,
    output logic [15:0] owner_id,
    output logic        is_locked,
    output logic [4:0]  waiting_count
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    seq_state_t         state_reg, state_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [ID_BITS-1:0] carry_reg, carry_next;
    logic [ID_BITS-1:0] owner_reg, owner_next;
    logic               held_reg, held_next;
    logic               done_reg, done_next;
    status_t            status_reg, status_next;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ID_BITS-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [ID_BITS-1:0] mem_rdata;

    logic [ID_BITS-1:0] req_id;
    logic [CW-1:0]      idx_inc;
    logic               at_last;
    logic               list_full;

    // Mask the request id down to the id width in use.
    assign req_id    = ID_BITS'(requester_id);
    assign idx_inc   = idx_reg + CW'(1);
    assign at_last   = (idx_inc == count_reg);
    assign list_full = (count_reg == CW'(LIST_DEPTH));

    plc_mem #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (ID_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_IDLE;
            idx_reg    <= '0;
            count_reg  <= '0;
            owner_reg  <= '0;
            held_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_GRANTED;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            owner_reg  <= owner_next;
            held_reg   <= held_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    // Request id and shift carry are payload only.
    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        carry_reg <= carry_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        id_next     = id_reg;
        carry_next  = carry_reg;
        owner_next  = owner_reg;
        held_next   = held_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;

        case (state_reg)
            SEQ_IDLE:
            begin
                // Keep the list head on the read port so a walk can start
                // in the next cycle.
                mem_raddr = '0;
                idx_next  = '0;
                if (start)
                begin
                    id_next = req_id;
                    if (command == CMD_RELEASE)
                    begin
                        if (count_reg == '0)
                        begin
                            held_next   = 1'b0;
                            owner_next  = '0;
                            done_next   = 1'b1;
                            status_next = ST_FREED;
                        end
                        else
                        begin
                            state_next = SEQ_HEAD;
                        end
                    end
                    else if (req_id == '0)
                    begin
                        // Zero marks an empty slot: refuse it.
                        done_next   = 1'b1;
                        status_next = ST_FULL;
                    end
                    else if (!held_reg)
                    begin
                        held_next   = 1'b1;
                        owner_next  = req_id;
                        done_next   = 1'b1;
                        status_next = ST_GRANTED;
                    end
                    else if (req_id == owner_reg)
                    begin
                        // The holder is never queued.
                        done_next   = 1'b1;
                        status_next = ST_WAITING;
                    end
                    else if (count_reg == '0)
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = '0;
                        mem_wdata   = req_id;
                        count_next  = CW'(1);
                        done_next   = 1'b1;
                        status_next = ST_QUEUED;
                    end
                    else
                    begin
                        state_next = SEQ_SCAN;
                    end
                end
            end

            SEQ_SCAN:
            begin
                // mem_rdata holds entry idx_reg.
                if (mem_rdata == id_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_WAITING;
                    state_next  = SEQ_IDLE;
                end
                else if (mem_rdata < id_reg)
                begin
                    if (list_full)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FULL;
                        state_next  = SEQ_IDLE;
                    end
                    else
                    begin
                        // Drop the new id in here and carry the old entry on.
                        mem_we     = 1'b1;
                        mem_waddr  = AW'(idx_reg);
                        mem_wdata  = id_reg;
                        carry_next = mem_rdata;
                        idx_next   = idx_inc;
                        mem_raddr  = AW'(idx_inc);
                        state_next = SEQ_INSERT;
                    end
                end
                else if (at_last)
                begin
                    if (list_full)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = AW'(count_reg);
                        mem_wdata   = id_reg;
                        count_next  = count_reg + CW'(1);
                        done_next   = 1'b1;
                        status_next = ST_QUEUED;
                    end
                    state_next = SEQ_IDLE;
                end
                else
                begin
                    idx_next  = idx_inc;
                    mem_raddr = AW'(idx_inc);
                end
            end

            SEQ_INSERT:
            begin
                // Write the carried entry one slot down, pick up the next.
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_reg);
                mem_wdata = carry_reg;
                if (idx_reg == count_reg)
                begin
                    count_next  = count_reg + CW'(1);
                    done_next   = 1'b1;
                    status_next = ST_QUEUED;
                    state_next  = SEQ_IDLE;
                end
                else
                begin
                    carry_next = mem_rdata;
                    idx_next   = idx_inc;
                    mem_raddr  = AW'(idx_inc);
                end
            end

            SEQ_HEAD:
            begin
                // Hand the lock to the list head.
                owner_next = mem_rdata;
                held_next  = 1'b1;
                if (count_reg == CW'(1))
                begin
                    count_next  = '0;
                    done_next   = 1'b1;
                    status_next = ST_HANDED;
                    state_next  = SEQ_IDLE;
                end
                else
                begin
                    idx_next   = CW'(1);
                    mem_raddr  = AW'(1);
                    state_next = SEQ_PULL;
                end
            end

            SEQ_PULL:
            begin
                // Advance each remaining entry one slot toward the head.
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_reg - CW'(1));
                mem_wdata = mem_rdata;
                if (at_last)
                begin
                    count_next  = count_reg - CW'(1);
                    done_next   = 1'b1;
                    status_next = ST_HANDED;
                    state_next  = SEQ_IDLE;
                end
                else
                begin
                    idx_next  = idx_inc;
                    mem_raddr = AW'(idx_inc);
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != SEQ_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign owner_id      = 16'(owner_reg);
    assign is_locked     = held_reg;
    assign waiting_count = 5'(count_reg);

    // A free lock has nobody waiting.
    a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !held_reg |-> (count_reg == '0))
        else $error("waiting list not empty while lock is free");

    // Every result leaves the sequencer idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == SEQ_IDLE))
        else $error("result strobed while sequencer busy");

    // A taken request either finishes at once or keeps the block busy.
    a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done_reg || busy))
        else $error("request lost");

    // A queued request grows the list by exactly one.
    a_queue_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_QUEUED) |->
            (count_reg == $past(count_reg) + CW'(1)))
        else $error("queued request did not grow the list by one");

    // A freed lock reports no owner.
    a_freed_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_FREED) |-> (!held_reg && owner_reg == '0))
        else $error("freed lock still has an owner");

endmodule

@@ tb/priority_lock_arbiter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_lock_arbiter_tb: self-checking bench for the priority lock arbiter
// Walks a short table of hand-picked requests, then about a thousand random
// acquire and release requests. A behavioral copy of the lock and its sorted
// waiting list predicts every result, and each done strobe is checked field by
// field against the oldest prediction, or the hand-typed answer of its row.
// ----------------------------------------------------------------------------
module priority_lock_arbiter_tb
    import plc_pkg::*;
();

    localparam int LIST_DEPTH   = 16;
    localparam int ID_POOL_SIZE = 24;
    localparam int RANDOM_ITEMS = 1050;
    localparam int CALM_ITEMS   = 150;   // last requests go back to back
    localparam int DRAIN_CYCLES = LIST_DEPTH + 8;
    localparam int STALL_LIMIT  = 2000;

    // One result as the block reports it.
    typedef struct packed {
        status_t     status;
        logic [15:0] owner_id;
        logic        is_locked;
        logic [4:0]  waiting_count;
    } lock_answer_t;

    // One row of the directed table: a request, and the answer when it is
    // obvious enough to type in by hand.
    typedef struct packed {
        logic         cmd;
        logic [15:0]  id;
        bit           typed;
        lock_answer_t answer;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        command;
    logic [15:0] requester_id;
    logic        done;
    logic [2:0]  status;
    logic [15:0] owner_id;
    logic        is_locked;
    logic [4:0]  waiting_count;

    // Hand-typed answer that goes with the request now on the ports.
    bit           row_typed;
    lock_answer_t row_answer;

    // Predicted lock state.
    logic [15:0] waiters [LIST_DEPTH];
    logic [15:0] lock_owner;
    logic        lock_held;
    int          waiter_count;

    lock_answer_t pending_answers [$];
    stim_row_t    directed_rows [$];
    int           mismatches;
    bit           allow_gaps;

    priority_lock_arbiter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .requester_id (requester_id),
        .done         (done),
        .status       (status),
        .owner_id     (owner_id),
        .is_locked    (is_locked),
        .waiting_count(waiting_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: apply one request to the lock and its waiting list and
    // return the answer the block must give.
    // ------------------------------------------------------------------------
    function automatic lock_answer_t arbitrate(input logic cmd, input logic [15:0] id);
        lock_answer_t ans;
        int           pos;
        int           i;
        bit           seen;
        bit           stop;
        begin
            if (cmd == CMD_RELEASE) begin
                // The id is ignored: any requester may release.
                if (waiter_count == 0) begin
                    lock_held  = 1'b0;
                    lock_owner = '0;
                    ans.status = ST_FREED;
                end
                else begin
                    // Hand the lock to the head and pull the list up one slot.
                    lock_owner = waiters[0];
                    lock_held  = 1'b1;
                    for (i = 0; i < waiter_count - 1; i++)
                        waiters[i] = waiters[i + 1];
                    waiter_count--;
                    waiters[waiter_count] = '0;
                    ans.status = ST_HANDED;
                end
            end
            else if (id == '0) begin
                // Zero marks an empty slot, so it can never be queued.
                ans.status = ST_FULL;
            end
            else if (!lock_held) begin
                lock_held  = 1'b1;
                lock_owner = id;
                ans.status = ST_GRANTED;
            end
            else if (id == lock_owner) begin
                ans.status = ST_WAITING;
            end
            else begin
                // Scan the descending list: an equal entry means already
                // waiting, the first smaller entry marks the insert point.
                pos  = waiter_count;
                seen = 1'b0;
                stop = 1'b0;
                for (i = 0; i < waiter_count && !stop; i++) begin
                    if (waiters[i] == id) begin
                        seen = 1'b1;
                        stop = 1'b1;
                    end
                    else if (waiters[i] < id) begin
                        pos  = i;
                        stop = 1'b1;
                    end
                end
                if (seen)
                    ans.status = ST_WAITING;
                else if (waiter_count >= LIST_DEPTH)
                    ans.status = ST_FULL;
                else begin
                    for (i = waiter_count; i > pos; i--)
                        waiters[i] = waiters[i - 1];
                    waiters[pos] = id;
                    waiter_count++;
                    ans.status = ST_QUEUED;
                end
            end
            ans.owner_id      = lock_owner;
            ans.is_locked     = lock_held;
            ans.waiting_count = waiter_count[4:0];
            return ans;
        end
    endfunction

    function automatic stim_row_t predicted_row(input logic cmd, input logic [15:0] id);
        stim_row_t row;
        begin
            row.cmd    = cmd;
            row.id     = id;
            row.typed  = 1'b0;
            row.answer = '0;
            return row;
        end
    endfunction

    function automatic stim_row_t checked_row(input logic cmd, input logic [15:0] id,
                                              input status_t st, input logic [15:0] own,
                                              input logic lk, input logic [4:0] cnt);
        stim_row_t row;
        begin
            row.cmd                  = cmd;
            row.id                   = id;
            row.typed                = 1'b1;
            row.answer.status        = st;
            row.answer.owner_id      = own;
            row.answer.is_locked     = lk;
            row.answer.waiting_count = cnt;
            return row;
        end
    endfunction

    task automatic compare_field(input string name, input logic [15:0] expv,
                                 input logic [15:0] actv);
        begin
            if (actv !== expv) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
                mismatches++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Drive one request from a falling edge, hold it until the block takes
    // it, and return at the next falling edge with start still high. Drop
    // start for a random burst now and then while gaps are allowed.
    // ------------------------------------------------------------------------
    task automatic send_request(input stim_row_t row);
        begin
            command      = row.cmd;
            requester_id = row.id;
            row_typed    = row.typed;
            row_answer   = row.answer;
            start        = 1'b1;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            @(negedge clk);
            if (allow_gaps && $urandom_range(0, 3) == 0) begin
                start = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
    endtask

    // Hold off new requests until every outstanding result has come back.
    task automatic wait_for_quiet();
        begin
            start = 1'b0;
            while (pending_answers.size() != 0)
                @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: check results, record accepted requests, and watch for a hang.
    // Everything here samples the values that stood just before the edge.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        lock_answer_t want;
        bit           progress;
        int           stall_cycles;
        if (rst_n) begin
            progress = 1'b0;
            if (done) begin
                progress = 1'b1;
                if (pending_answers.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d owner %0h",
                             $time, status, owner_id);
                    mismatches++;
                end
                else begin
                    want = pending_answers.pop_front();
                    compare_field("status", 16'(want.status), 16'(status));
                    compare_field("owner_id", want.owner_id, owner_id);
                    compare_field("is_locked", 16'(want.is_locked), 16'(is_locked));
                    compare_field("waiting_count", 16'(want.waiting_count),
                                  16'(waiting_count));
                end
            end
            // Advance the predictor on every accepted request; a typed row
            // still moves the state, but its own answer is what gets checked.
            if (start && !busy) begin
                progress = 1'b1;
                want = arbitrate(command, requester_id);
                if (row_typed)
                    want = row_answer;
                pending_answers.push_back(want);
            end
            if (progress)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no request or result for %0d cycles", $time, STALL_LIMIT);
                $display("** priority_lock_arbiter: FAILED **");
                $finish;
            end
        end
        else begin
            stall_cycles = 0;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [15:0] id_pool [ID_POOL_SIZE];
        logic [15:0] id;
        logic        cmd;
        int          i;
        int          r;
        int          acquire_pct;

        rst_n        = 1'b0;
        start        = 1'b0;
        command      = CMD_ACQUIRE;
        requester_id = '0;
        row_typed    = 1'b0;
        row_answer   = '0;
        mismatches   = 0;
        allow_gaps   = 1'b1;
        lock_owner   = '0;
        lock_held    = 1'b0;
        waiter_count = 0;
        for (i = 0; i < LIST_DEPTH; i++)
            waiters[i] = '0;
        acquire_pct = 50;

        // Directed rows: lock corners first, then fill the list to the top.
        directed_rows.push_back(checked_row(CMD_RELEASE, 16'h0000, ST_FREED, 16'h0000, 1'b0, 5'd0));
        directed_rows.push_back(checked_row(CMD_ACQUIRE, 16'h0000, ST_FULL, 16'h0000, 1'b0, 5'd0));
        directed_rows.push_back(checked_row(CMD_ACQUIRE, 16'hFFFF, ST_GRANTED, 16'hFFFF, 1'b1, 5'd0));
        directed_rows.push_back(checked_row(CMD_ACQUIRE, 16'hFFFF, ST_WAITING, 16'hFFFF, 1'b1, 5'd0));
        directed_rows.push_back(checked_row(CMD_ACQUIRE, 16'h0001, ST_QUEUED, 16'hFFFF, 1'b1, 5'd1));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h8000));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h0001));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h5555));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'hAAAA));
        directed_rows.push_back(checked_row(CMD_ACQUIRE, 16'h0000, ST_FULL, 16'hFFFF, 1'b1, 5'd4));
        // Release carries a stray id, which the block must ignore.
        directed_rows.push_back(predicted_row(CMD_RELEASE, 16'h1234));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h0002));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'hFFFE));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h7FFF));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h1000));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h0100));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h0010));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'hF000));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h0F00));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h00F0));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h000F));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h4000));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h2000));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h0800));
        // List is full now: a new id is refused, a waiting one is recognized.
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h3333));
        directed_rows.push_back(predicted_row(CMD_ACQUIRE, 16'h0010));

        for (i = 0; i < ID_POOL_SIZE; i++)
            id_pool[i] = 16'($urandom_range(1, 65535));

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
            send_request(directed_rows[k]);
        wait_for_quiet();

        // Random part: mostly ids from a small pool so that duplicates, holder
        // re-acquires and a full list all come up; the acquire share changes
        // every hundred requests so the list both fills and drains.
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0: acquire_pct = 25;
                    1: acquire_pct = 50;
                    2: acquire_pct = 65;
                    default: acquire_pct = 85;
                endcase
            end
            if (i >= RANDOM_ITEMS - CALM_ITEMS)
                allow_gaps = 1'b0;
            cmd = ($urandom_range(1, 100) <= acquire_pct) ? CMD_ACQUIRE : CMD_RELEASE;
            r = $urandom_range(0, 99);
            if (r < 4)
                id = '0;
            else if (r < 8)
                id = 16'hFFFF;
            else if (r < 14 && lock_held)
                id = lock_owner;
            else if (r < 70)
                id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
            else
                id = 16'($urandom);
            send_request(predicted_row(cmd, id));
            if (i == RANDOM_ITEMS / 2) begin
                wait_for_quiet();
                @(negedge clk);
            end
        end

        // Drain: wait for the last results, then watch a while for strays.
        wait_for_quiet();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0) begin
            $display("** priority_lock_arbiter: PASSED **");
        end
        else begin
            $display("** priority_lock_arbiter: FAILED **");
        end
        $finish;
    end

endmodule

@@ priority_lock_arbiter.f @@
src/plc_pkg.sv
src/plc_mem.sv
src/priority_lock_arbiter.sv
tb/priority_lock_arbiter_tb.sv
